// ----- rtl/oacs_pkg.sv -----
// ============================================================================
// oacs_pkg
// Shared widths, codes and types for the obstacle-avoidance command selector.
// ============================================================================
package oacs_pkg;

  localparam int RANGE_W   = 16;
  localparam int DIST_W    = 16;
  localparam int TIME_W    = 32;
  localparam int MASK_W    = 5;
  localparam int CMD_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Bit positions in the whisker mask.
  localparam int MB_LEFT_SIDE  = 4;
  localparam int MB_LEFT_BOW   = 3;
  localparam int MB_AHEAD      = 2;
  localparam int MB_RIGHT_BOW  = 1;
  localparam int MB_RIGHT_SIDE = 0;

  localparam logic [MASK_W-1:0] MASK_ONLY_LEFT_SIDE  = MASK_W'(1) << MB_LEFT_SIDE;
  localparam logic [MASK_W-1:0] MASK_ONLY_RIGHT_SIDE = MASK_W'(1) << MB_RIGHT_SIDE;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIDE_TRIP  = 3'd0,
    CFG_BOW_TRIP   = 3'd1,
    CFG_AHEAD_TRIP = 3'd2,
    CFG_DANGER     = 3'd3,
    CFG_MANEUVER   = 3'd4
  } cfg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_EASY_FWD     = 4'd0,
    CMD_BACK_CW      = 4'd1,
    CMD_BACK_CCW     = 4'd2,
    CMD_BACK         = 4'd3,
    CMD_FWD          = 4'd4,
    CMD_TWIST_RIGHT  = 4'd5,
    CMD_SWERVE_RIGHT = 4'd6,
    CMD_SWERVE_LEFT  = 4'd7,
    CMD_EASE_RIGHT   = 4'd8,
    CMD_EASE_LEFT    = 4'd9
  } cmd_t;

  typedef struct packed {
    logic               left_bumper;
    logic               right_bumper;
    logic [RANGE_W-1:0] range_left_side;
    logic [RANGE_W-1:0] range_left_bow;
    logic [RANGE_W-1:0] range_ahead;
    logic [RANGE_W-1:0] range_right_bow;
    logic [RANGE_W-1:0] range_right_side;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    cmd_t              command;
    logic [MASK_W-1:0] whisker_mask;
    logic              danger_flag;
  } out_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] side_trip_distance;
    logic [DIST_W-1:0] bow_trip_distance;
    logic [DIST_W-1:0] ahead_trip_distance;
    logic [DIST_W-1:0] danger_distance;
    logic [DIST_W-1:0] maneuver_time_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic [TIME_W-1:0] maneuver_end;
    logic              left_latched;
    logic              right_latched;
  } bump_state_t;

endpackage

// ----- rtl/oacs_ifs.sv -----
// ============================================================================
// oacs channel interfaces
// Valid/ready channels for input beats, result beats and register writes.
// ============================================================================
interface oacs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        left_bumper;
  logic                        right_bumper;
  logic [oacs_pkg::RANGE_W-1:0] range_left_side;
  logic [oacs_pkg::RANGE_W-1:0] range_left_bow;
  logic [oacs_pkg::RANGE_W-1:0] range_ahead;
  logic [oacs_pkg::RANGE_W-1:0] range_right_bow;
  logic [oacs_pkg::RANGE_W-1:0] range_right_side;
  logic [oacs_pkg::TIME_W-1:0]  now_ms;

  modport source (
    output valid, left_bumper, right_bumper, range_left_side, range_left_bow,
           range_ahead, range_right_bow, range_right_side, now_ms,
    input  ready
  );
  modport sink (
    input  valid, left_bumper, right_bumper, range_left_side, range_left_bow,
           range_ahead, range_right_bow, range_right_side, now_ms,
    output ready
  );
endinterface

interface oacs_out_if;
  logic                        valid;
  logic                        ready;
  logic [oacs_pkg::CMD_W-1:0]  command;
  logic [oacs_pkg::MASK_W-1:0] whisker_mask;
  logic                        danger_flag;

  modport source (output valid, command, whisker_mask, danger_flag, input ready);
  modport sink   (input valid, command, whisker_mask, danger_flag, output ready);
endinterface

interface oacs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [oacs_pkg::CFG_IDX_W-1:0] index;
  logic [oacs_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/obstacle_avoid_command_select_unit.sv -----
// ============================================================================
// obstacle_avoid_command_select_unit
// Picks a drive command from bumpers, five range readings and the time.
// ============================================================================
//
//   channel | role    | beat carries
//   --------+---------+---------------------------------------------------
//   in_ch   | sink    | two bumper flags, five ranges, millisecond time
//   out_ch  | source  | command code, whisker mask, danger flag
//   cfg_ch  | sink    | register index and 16-bit value (always ready)
//
// Every beat is accepted into the input register, and moves on through the
// decision logic into the output register when that register may load. A
// new beat is accepted every cycle while the result side drains.
// The bump state (end time and the two latches) is updated as a beat moves
// from the input register to the output register, so beats see it in order.
// Reset (synchronous, active low) clears both stage valids, the bump state
// and all configuration registers. A stalled output holds its beat and,
// through the ready chain, stops the input register from moving on.
//
module obstacle_avoid_command_select_unit (
  input logic       clk,
  input logic       rst_n,
  oacs_in_if.sink   in_ch,
  oacs_out_if.source out_ch,
  oacs_cfg_if.sink  cfg_ch
);
  import oacs_pkg::*;

  cfg_regs_t   cfg_r;
  bump_state_t state_r;
  bump_state_t state_nxt;
  in_item_t    in_item;
  in_item_t    s1_item_r;
  logic        s1_valid_r;
  out_item_t   result;
  out_item_t   out_item_r;
  logic        out_valid_r;
  logic        out_load;
  logic        advance;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_SIDE_TRIP:  cfg_r.side_trip_distance  <= cfg_ch.data;
        CFG_BOW_TRIP:   cfg_r.bow_trip_distance   <= cfg_ch.data;
        CFG_AHEAD_TRIP: cfg_r.ahead_trip_distance <= cfg_ch.data;
        CFG_DANGER:     cfg_r.danger_distance     <= cfg_ch.data;
        CFG_MANEUVER:   cfg_r.maneuver_time_ms    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign in_item = '{
    left_bumper:      in_ch.left_bumper,
    right_bumper:     in_ch.right_bumper,
    range_left_side:  in_ch.range_left_side,
    range_left_bow:   in_ch.range_left_bow,
    range_ahead:      in_ch.range_ahead,
    range_right_bow:  in_ch.range_right_bow,
    range_right_side: in_ch.range_right_side,
    now_ms:           in_ch.now_ms
  };

  // The output register may load when empty or when its beat is being taken;
  // the input register may load when empty or when it is moving on.
  assign out_load    = !out_valid_r || out_ch.ready;
  assign advance     = s1_valid_r && out_load;
  assign in_ch.ready = !s1_valid_r || out_load;

  oacs_decide u_decide (
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .state     (state_r),
    .result    (result),
    .state_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.command      = out_item_r.command;
  assign out_ch.whisker_mask = out_item_r.whisker_mask;
  assign out_ch.danger_flag  = out_item_r.danger_flag;

`ifndef SYNTHESIS
  // A clockwise back-off is only shown while the left latch is held.
  a_back_cw_latched : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.command == CMD_BACK_CW) |-> state_r.left_latched)
    else $error("back cw command without left latch");

  // A beat leaving the input register appears at the output next cycle.
  a_advance_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced beat lost");

  // Danger close gives back away unless a bump maneuver is running.
  a_danger_backs : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.danger_flag &&
     !(out_item_r.command == CMD_BACK_CW || out_item_r.command == CMD_BACK_CCW))
    |-> out_item_r.command == CMD_BACK)
    else $error("danger without back command");

  // The bump state only moves with a beat.
  a_state_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("bump state changed without a beat");
`endif

endmodule

// ----- rtl/oacs_decide.sv -----
// ============================================================================
// oacs_decide
// Range comparisons, bump latch update and priority command choice.
// ============================================================================
module oacs_decide (
  input  oacs_pkg::in_item_t    item,
  input  oacs_pkg::cfg_regs_t   cfg,
  input  oacs_pkg::bump_state_t state,
  output oacs_pkg::out_item_t   result,
  output oacs_pkg::bump_state_t state_nxt
);
  import oacs_pkg::*;

  logic [MASK_W-1:0] mask;
  logic              danger;
  logic              bump;
  logic [TIME_W-1:0] end_time;
  logic              left_set;
  logic              right_set;
  logic              expired;
  logic              active;
  cmd_t              cmd;

  always_comb begin
    mask                = '0;
    mask[MB_LEFT_SIDE]  = item.range_left_side  < cfg.side_trip_distance;
    mask[MB_LEFT_BOW]   = item.range_left_bow   < cfg.bow_trip_distance;
    mask[MB_AHEAD]      = item.range_ahead      < cfg.ahead_trip_distance;
    mask[MB_RIGHT_BOW]  = item.range_right_bow  < cfg.bow_trip_distance;
    mask[MB_RIGHT_SIDE] = item.range_right_side < cfg.side_trip_distance;
  end

  assign danger = (item.range_ahead     < cfg.danger_distance) ||
                  (item.range_right_bow < cfg.danger_distance) ||
                  (item.range_left_bow  < cfg.danger_distance);

  // The left bumper wins when both are pressed.
  assign bump      = item.left_bumper || item.right_bumper;
  assign end_time  = bump ? item.now_ms + TIME_W'(cfg.maneuver_time_ms)
                          : state.maneuver_end;
  assign left_set  = item.left_bumper || state.left_latched;
  assign right_set = (!item.left_bumper && item.right_bumper) || state.right_latched;
  assign expired   = item.now_ms > end_time;
  assign active    = item.now_ms < end_time;

  assign state_nxt.maneuver_end  = end_time;
  assign state_nxt.left_latched  = left_set  && !expired;
  assign state_nxt.right_latched = right_set && !expired;

  always_comb begin
    if (active && state_nxt.left_latched) begin
      cmd = CMD_BACK_CW;
    end else if (active && state_nxt.right_latched) begin
      cmd = CMD_BACK_CCW;
    end else if (danger) begin
      cmd = CMD_BACK;
    end else if (mask == '0) begin
      cmd = CMD_FWD;
    end else if (mask[MB_AHEAD]) begin
      cmd = CMD_TWIST_RIGHT;
    end else if (mask[MB_LEFT_BOW]) begin
      cmd = CMD_SWERVE_RIGHT;
    end else if (mask[MB_RIGHT_BOW]) begin
      cmd = CMD_SWERVE_LEFT;
    end else if (mask == MASK_ONLY_LEFT_SIDE) begin
      cmd = CMD_EASE_RIGHT;
    end else if (mask == MASK_ONLY_RIGHT_SIDE) begin
      cmd = CMD_EASE_LEFT;
    end else begin
      cmd = CMD_EASY_FWD;
    end
  end

  assign result.command      = cmd;
  assign result.whisker_mask = mask;
  assign result.danger_flag  = danger;

endmodule

// ----- sim/oacs_cmd_checker.sv -----
// ----------------------------------------------------------------------------
// oacs_cmd_checker
// Watches the input, result and register channels of the command selector,
// keeps its own copy of the registers and the bump state, and compares every
// result beat with the command it predicts for the oldest beat still owed.
// ----------------------------------------------------------------------------
module oacs_cmd_checker (
  input  logic clk,
  input  logic rst_n,
  oacs_in_if   in_ch,
  oacs_out_if  out_ch,
  oacs_cfg_if  cfg_ch,
  output int   fail_count,
  output int   outstanding,
  output int   beats_checked,
  output int   bump_cmds
);
  timeunit 1ns;
  timeprecision 1ps;
  import oacs_pkg::*;

  cfg_regs_t   regs;
  bump_state_t bump;
  out_item_t   due_cmds[$];
  int          fails;
  int          reported;
  int          checked;
  int          bumps;

  // Decision logic for one control cycle. It moves the bump state on exactly
  // as the block does when the beat passes its decision stage.
  function automatic out_item_t pick_command(in_item_t b);
    out_item_t         r;
    logic [MASK_W-1:0] m;
    logic              close;
    m = '0;
    m[MB_LEFT_SIDE]  = b.range_left_side  < regs.side_trip_distance;
    m[MB_LEFT_BOW]   = b.range_left_bow   < regs.bow_trip_distance;
    m[MB_AHEAD]      = b.range_ahead      < regs.ahead_trip_distance;
    m[MB_RIGHT_BOW]  = b.range_right_bow  < regs.bow_trip_distance;
    m[MB_RIGHT_SIDE] = b.range_right_side < regs.side_trip_distance;
    close = (b.range_ahead < regs.danger_distance) ||
            (b.range_right_bow < regs.danger_distance) ||
            (b.range_left_bow < regs.danger_distance);

    if (b.left_bumper || b.right_bumper) begin
      bump.maneuver_end = b.now_ms + TIME_W'(regs.maneuver_time_ms);
      if (b.left_bumper) begin
        bump.left_latched = 1'b1;
      end else begin
        bump.right_latched = 1'b1;
      end
    end
    if (b.now_ms > bump.maneuver_end) begin
      bump.left_latched  = 1'b0;
      bump.right_latched = 1'b0;
    end

    if (b.now_ms < bump.maneuver_end && bump.left_latched) begin
      r.command = CMD_BACK_CW;
    end else if (b.now_ms < bump.maneuver_end && bump.right_latched) begin
      r.command = CMD_BACK_CCW;
    end else if (close) begin
      r.command = CMD_BACK;
    end else if (m == '0) begin
      r.command = CMD_FWD;
    end else if (m[MB_AHEAD]) begin
      r.command = CMD_TWIST_RIGHT;
    end else if (m[MB_LEFT_BOW]) begin
      r.command = CMD_SWERVE_RIGHT;
    end else if (m[MB_RIGHT_BOW]) begin
      r.command = CMD_SWERVE_LEFT;
    end else if (m == MASK_ONLY_LEFT_SIDE) begin
      r.command = CMD_EASE_RIGHT;
    end else if (m == MASK_ONLY_RIGHT_SIDE) begin
      r.command = CMD_EASE_LEFT;
    end else begin
      r.command = CMD_EASY_FWD;
    end
    r.whisker_mask = m;
    r.danger_flag  = close;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    in_item_t  b;
    out_item_t want;
    if (!rst_n) begin
      regs = '0;
      bump = '0;
      due_cmds.delete();
    end else begin
      // Results are taken before new beats are queued, so a result can never
      // be matched against a beat accepted on the same edge.
      if (out_ch.valid && out_ch.ready) begin
        if (due_cmds.size() == 0) begin
          fails++;
          reported++;
          if (reported <= 10) begin
            $display("%0t: result beat with nothing owed: cmd %0d mask %b danger %b",
                     $realtime, out_ch.command, out_ch.whisker_mask, out_ch.danger_flag);
          end
        end else begin
          want = due_cmds.pop_front();
          checked++;
          if (want.command == CMD_BACK_CW || want.command == CMD_BACK_CCW) begin
            bumps++;
          end
          if (out_ch.command !== want.command || out_ch.whisker_mask !== want.whisker_mask ||
              out_ch.danger_flag !== want.danger_flag) begin
            fails++;
            reported++;
            if (reported <= 10) begin
              $display("%0t: result %0d wrong: want cmd %0d mask %b danger %b,",
                       $realtime, checked, want.command, want.whisker_mask,
                       want.danger_flag);
              $display("    got cmd %0d mask %b danger %b",
                       out_ch.command, out_ch.whisker_mask, out_ch.danger_flag);
            end
          end
        end
      end

      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_SIDE_TRIP:  regs.side_trip_distance  = cfg_ch.data;
          CFG_BOW_TRIP:   regs.bow_trip_distance   = cfg_ch.data;
          CFG_AHEAD_TRIP: regs.ahead_trip_distance = cfg_ch.data;
          CFG_DANGER:     regs.danger_distance     = cfg_ch.data;
          CFG_MANEUVER:   regs.maneuver_time_ms    = cfg_ch.data;
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        b.left_bumper      = in_ch.left_bumper;
        b.right_bumper     = in_ch.right_bumper;
        b.range_left_side  = in_ch.range_left_side;
        b.range_left_bow   = in_ch.range_left_bow;
        b.range_ahead      = in_ch.range_ahead;
        b.range_right_bow  = in_ch.range_right_bow;
        b.range_right_side = in_ch.range_right_side;
        b.now_ms           = in_ch.now_ms;
        due_cmds.insert(due_cmds.size(), pick_command(b));
      end
    end
    fail_count    <= fails;
    outstanding   <= due_cmds.size();
    beats_checked <= checked;
    bump_cmds     <= bumps;
  end

endmodule

// ----- sim/obstacle_avoid_command_select_unit_tb.sv -----
// ----------------------------------------------------------------------------
// obstacle_avoid_command_select_unit_tb
// Drives control cycles into the command selector through its valid/ready
// channels: a directed set covering every command, the bump latches, time wrap
// and the register extremes, then random scenes under several register
// settings with random stalls on both sides and one long result hold-off.
// Checking is done by oacs_cmd_checker, which sits beside the block.
// ----------------------------------------------------------------------------
module obstacle_avoid_command_select_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import oacs_pkg::*;

  localparam int CYCLE_LIMIT   = 400_000;
  localparam int HOLD_CYCLES   = 80;
  localparam int PHASE_BEATS   = 325;
  localparam int RANDOM_PHASES = 6;
  localparam int IDLE_PERCENT  = 29;
  // The beat takes two register stages, so this settle time after the last
  // result is plenty for the block to be fully at rest.
  localparam int SETTLE_CYCLES = 4;
  localparam logic [RANGE_W-1:0] FAR = '1;
  // First register index that the block decodes to nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(CFG_MANEUVER + 1);

  logic clk;
  logic rst_n;

  oacs_in_if  in_ch();
  oacs_out_if out_ch();
  oacs_cfg_if cfg_ch();

  int fail_count;
  int outstanding;
  int beats_checked;
  int bump_cmds;

  // Shared between the sender, the receiver and the scene generator.
  bit                quiet;
  bit                hold_req;
  int                cycle_count;
  int                beats_sent;
  int                settings_done;
  logic [TIME_W-1:0] clock_ms;
  logic [DIST_W-1:0] cur_side, cur_bow, cur_ahead, cur_danger;

  obstacle_avoid_command_select_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  oacs_cmd_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .beats_checked (beats_checked),
    .bump_cmds     (bump_cmds)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Overall guard: if the run has not finished by now, something has hung.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("obstacle_avoid_command_select_unit_tb: done, errors");
    $finish;
  end

  // Result side. Normally ready drops at random; when the stimulus asks for a
  // hold-off, ready is kept low for the whole hold-off so that both stages of
  // the block fill and the input side is pushed back.
  initial begin : result_side
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
        @(posedge clk);
      end
    end
  end

  function automatic in_item_t mk_beat(logic lb, logic rb, logic [RANGE_W-1:0] ls,
                                       logic [RANGE_W-1:0] lbw, logic [RANGE_W-1:0] ah,
                                       logic [RANGE_W-1:0] rbw, logic [RANGE_W-1:0] rs,
                                       logic [TIME_W-1:0] now);
    in_item_t b;
    b.left_bumper      = lb;
    b.right_bumper     = rb;
    b.range_left_side  = ls;
    b.range_left_bow   = lbw;
    b.range_ahead      = ah;
    b.range_right_bow  = rbw;
    b.range_right_side = rs;
    b.now_ms           = now;
    return b;
  endfunction

  // A range that trips the given distance, often sitting just under it.
  // With a distance of zero nothing can trip, so any value will do.
  function automatic logic [RANGE_W-1:0] short_of(logic [DIST_W-1:0] trip);
    if (trip == '0) begin
      return RANGE_W'($urandom);
    end
    if ($urandom_range(0, 9) < 3) begin
      return trip - 1'b1;
    end
    return RANGE_W'($urandom_range(0, trip - 1'b1));
  endfunction

  // A range that stays clear of the given distance, often exactly on it.
  function automatic logic [RANGE_W-1:0] clear_of(logic [DIST_W-1:0] trip);
    if ($urandom_range(0, 9) < 3) begin
      return trip;
    end
    return RANGE_W'($urandom_range(trip, 16'hFFFF));
  endfunction

  // One random control cycle. Most are coherent scenes: time moves forward in
  // small steps so bump maneuvers run their course, and each sensor is put
  // deliberately on one side of its trip distance. A share are pure noise,
  // and time now and then jumps, steps back or sits just below the wrap.
  function automatic in_item_t random_scene();
    in_item_t          b;
    logic [MASK_W-1:0] tripped;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      clock_ms = clock_ms + TIME_W'($urandom_range(0, 40));
    end else if (pick < 86) begin
      clock_ms = $urandom;
    end else if (pick < 92) begin
      clock_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 800));
    end else if (pick < 96) begin
      clock_ms = clock_ms - TIME_W'($urandom_range(0, 50));
    end

    if ($urandom_range(0, 99) < 15) begin
      b.range_left_side  = RANGE_W'($urandom);
      b.range_left_bow   = RANGE_W'($urandom);
      b.range_ahead      = RANGE_W'($urandom);
      b.range_right_bow  = RANGE_W'($urandom);
      b.range_right_side = RANGE_W'($urandom);
      b.now_ms           = $urandom;
    end else begin
      tripped = MASK_W'($urandom);
      b.range_left_side  = tripped[MB_LEFT_SIDE]  ? short_of(cur_side)  : clear_of(cur_side);
      b.range_left_bow   = tripped[MB_LEFT_BOW]   ? short_of(cur_bow)   : clear_of(cur_bow);
      b.range_ahead      = tripped[MB_AHEAD]      ? short_of(cur_ahead) : clear_of(cur_ahead);
      b.range_right_bow  = tripped[MB_RIGHT_BOW]  ? short_of(cur_bow)   : clear_of(cur_bow);
      b.range_right_side = tripped[MB_RIGHT_SIDE] ? short_of(cur_side)  : clear_of(cur_side);
      // Sometimes put one middle sensor near the danger-close distance.
      case ($urandom_range(0, 9))
        0: b.range_left_bow  = short_of(cur_danger);
        1: b.range_ahead     = short_of(cur_danger);
        2: b.range_right_bow = short_of(cur_danger);
        3: b.range_ahead     = clear_of(cur_danger);
        default: ;
      endcase
      b.now_ms = clock_ms;
    end

    pick = $urandom_range(0, 99);
    b.left_bumper  = (pick < 6) || (pick >= 12 && pick < 15);
    b.right_bumper = (pick >= 6 && pick < 15);
    return b;
  endfunction

  // Offers one beat and returns on the edge at which it is accepted. Valid is
  // left high so that back-to-back beats keep it high without a glitch.
  task automatic push_beat(input in_item_t b);
    while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.left_bumper      <= b.left_bumper;
    in_ch.right_bumper     <= b.right_bumper;
    in_ch.range_left_side  <= b.range_left_side;
    in_ch.range_left_bow   <= b.range_left_bow;
    in_ch.range_ahead      <= b.range_ahead;
    in_ch.range_right_bow  <= b.range_right_bow;
    in_ch.range_right_side <= b.range_right_side;
    in_ch.now_ms           <= b.now_ms;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  // Stops offering beats and waits until every result owed has come back and
  // the pipeline has had time to empty.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Writes all five registers, preceded by a write to an undecoded index that
  // must leave everything unchanged. Only called while the block is at rest.
  task automatic apply_settings(input logic [DIST_W-1:0] side, bow, ahead, danger, hold_ms);
    put_reg(CFG_IDX_W'(CFG_SPARE + $urandom_range(0, 2)), CFG_DAT_W'($urandom));
    put_reg(CFG_SIDE_TRIP, side);
    put_reg(CFG_BOW_TRIP, bow);
    put_reg(CFG_AHEAD_TRIP, ahead);
    put_reg(CFG_DANGER, danger);
    put_reg(CFG_MANEUVER, hold_ms);
    cfg_ch.valid <= 1'b0;
    cur_side   = side;
    cur_bow    = bow;
    cur_ahead  = ahead;
    cur_danger = danger;
    settings_done++;
  endtask

  initial begin : stimulus
    logic [DIST_W-1:0] s, bw, ah, dg, mt;
    quiet    = 1'b0;
    hold_req = 1'b0;
    clock_ms = '0;
    cur_side = '0;
    cur_bow  = '0;
    cur_ahead  = '0;
    cur_danger = '0;
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.left_bumper      <= 1'b0;
    in_ch.right_bumper     <= 1'b0;
    in_ch.range_left_side  <= '0;
    in_ch.range_left_bow   <= '0;
    in_ch.range_ahead      <= '0;
    in_ch.range_right_bow  <= '0;
    in_ch.range_right_side <= '0;
    in_ch.now_ms           <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= '0;
    cfg_ch.data            <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at their reset value of zero: nothing can trip, and a bump
    // with a zero maneuver time ends at once but leaves its latch set until
    // a later time passes the end.
    push_beat(mk_beat(1'b1, 1'b0, '0, '0, '0, '0, '0, 32'd5));
    push_beat(mk_beat(1'b0, 1'b0, FAR, FAR, FAR, FAR, FAR, 32'd6));
    drain();

    // Hand-picked distances, one scene per command.
    apply_settings(16'd1000, 16'd2000, 16'd3000, 16'd500, 16'd100);
    push_beat(mk_beat(1'b0, 1'b0, FAR, FAR, FAR, FAR, FAR, 32'd10));
    push_beat(mk_beat(1'b0, 1'b0, FAR, FAR, 16'd1000, FAR, FAR, 32'd11));
    push_beat(mk_beat(1'b0, 1'b0, FAR, 16'd1500, FAR, FAR, FAR, 32'd12));
    push_beat(mk_beat(1'b0, 1'b0, FAR, FAR, FAR, 16'd1500, FAR, 32'd13));
    push_beat(mk_beat(1'b0, 1'b0, 16'd10, FAR, FAR, FAR, FAR, 32'd14));
    push_beat(mk_beat(1'b0, 1'b0, FAR, FAR, FAR, FAR, 16'd10, 32'd15));
    // Both side sensors alone fall through to the easy forward.
    push_beat(mk_beat(1'b0, 1'b0, 16'd999, FAR, FAR, FAR, 16'd999, 32'd16));
    push_beat(mk_beat(1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
    // Left bump: reverse clockwise until the end time, latch kept while time
    // equals the end, cleared once time passes it.
    push_beat(mk_beat(1'b1, 1'b0, FAR, FAR, FAR, FAR, FAR, 32'd1000));
    push_beat(mk_beat(1'b0, 1'b0, FAR, FAR, FAR, FAR, FAR, 32'd1050));
    push_beat(mk_beat(1'b0, 1'b0, FAR, FAR, FAR, FAR, FAR, 32'd1100));
    push_beat(mk_beat(1'b0, 1'b0, FAR, FAR, FAR, FAR, FAR, 32'd1101));
    // Right bump, then a bump command outranking danger close.
    push_beat(mk_beat(1'b0, 1'b1, FAR, FAR, FAR, FAR, FAR, 32'd2000));
    push_beat(mk_beat(1'b0, 1'b0, '0, '0, '0, '0, '0, 32'd2099));
    // Both bumpers: the left one wins.
    push_beat(mk_beat(1'b1, 1'b1, FAR, FAR, FAR, FAR, FAR, 32'd3000));
    // A bump just below the wrap gives an end time that is already past.
    push_beat(mk_beat(1'b1, 1'b0, FAR, FAR, FAR, FAR, FAR, 32'hFFFF_FFF0));
    push_beat(mk_beat(1'b0, 1'b0, 16'h5A5A, 16'hA5A5, 16'h5A5A, 16'hA5A5, 16'h5A5A,
                      32'hFFFF_FFFF));
    drain();

    // Every register at its top value.
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_beat(mk_beat(1'b0, 1'b0, FAR, FAR, FAR, FAR, FAR, 32'd7));
    push_beat(mk_beat(1'b0, 1'b0, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 32'd8));
    push_beat(mk_beat(1'b0, 1'b1, FAR, FAR, FAR, FAR, FAR, 32'hFFFF_0000));
    drain();

    // Random scenes, one block of beats per register setting.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          s  = DIST_W'($urandom_range(500, 20000));
          bw = DIST_W'($urandom_range(500, 20000));
          ah = DIST_W'($urandom_range(500, 20000));
          dg = DIST_W'($urandom_range(0, 3000));
          mt = DIST_W'($urandom_range(20, 400));
        end
        1: begin
          s  = '1;
          bw = '1;
          ah = '1;
          dg = '1;
          mt = '1;
        end
        2: begin
          s  = '0;
          bw = '0;
          ah = '0;
          dg = '0;
          mt = '0;
        end
        3: begin
          s  = DIST_W'($urandom);
          bw = DIST_W'($urandom);
          ah = DIST_W'($urandom);
          dg = DIST_W'($urandom);
          mt = DIST_W'($urandom);
        end
        4: begin
          s  = DIST_W'($urandom_range(0, 3000));
          bw = DIST_W'($urandom_range(0, 3000));
          ah = DIST_W'($urandom_range(0, 3000));
          dg = DIST_W'($urandom_range(20000, 65535));
          mt = DIST_W'($urandom_range(1, 50));
        end
        default: begin
          s  = DIST_W'($urandom_range(1000, 40000));
          bw = DIST_W'($urandom_range(1000, 40000));
          ah = DIST_W'($urandom_range(1000, 40000));
          dg = DIST_W'($urandom_range(0, 1000));
          mt = DIST_W'($urandom_range(0, 5));
        end
      endcase
      apply_settings(s, bw, ah, dg, mt);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // In the fourth block the result side is held off for a long while
        // with the sender offering every cycle, then both sides run without
        // any idling for a stretch.
        if (phase == 3 && n == 100) begin
          quiet    = 1'b1;
          hold_req = 1'b1;
        end
        if (phase == 3 && n == 260) begin
          quiet = 1'b0;
        end
        push_beat(random_scene());
      end
      drain();
    end

    $display("summary: %0d beats sent, %0d results checked, %0d register settings",
             beats_sent, beats_checked, settings_done);
    $display("summary: %0d bump reversals seen, one %0d-cycle result hold-off, %0d cycles",
             bump_cmds, HOLD_CYCLES, cycle_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("obstacle_avoid_command_select_unit_tb: done, clean");
    end else begin
      $display("obstacle_avoid_command_select_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
